### rtl/tla_pkg.sv
// Package with shared types, constants and the life rule for the toroidal life automaton.
`default_nettype none

package tla_pkg;

    localparam int ACTION_W  = 2;
    localparam int COL_W     = 4;
    localparam int ROW_W     = 4;
    localparam int GEN_W     = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2
    } t_action;

    // Control handed from the top level to one row cell.
    typedef struct packed {
        logic             step;
        logic             wr;
        logic [COL_W-1:0] col;
        logic             val;
    } t_cell_ctl;

    // B3/S23: born with exactly three live neighbours, survives with two or three.
    function automatic logic life_rule(input logic alive, input logic [7:0] nb);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + 4'(nb[k]);
        end
        return (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && alive);
    endfunction

endpackage

`default_nettype wire

### rtl/tla_row_cell.sv
// One row of the grid: holds its cells, applies cell writes and computes their next generation.
`default_nettype none

module tla_row_cell #(
    parameter int WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [WIDTH-1:0]     i_up,
    input  wire logic [WIDTH-1:0]     i_dn,
    input  wire tla_pkg::t_cell_ctl   i_ctl,
    output logic      [WIDTH-1:0]     o_row
);

    localparam int CMP_W = 9;

    logic [WIDTH-1:0] r_row;
    logic [WIDTH-1:0] n_row;

    for (genvar c = 0; c < WIDTH; c++) begin : g_col
        localparam int CL = (c + WIDTH - 1) % WIDTH;
        localparam int CR = (c + 1) % WIDTH;
        logic [7:0] w_nb;
        logic       w_life;
        logic       w_hit;

        assign w_nb = {i_up[CL], i_up[c], i_up[CR], r_row[CL], r_row[CR],
                       i_dn[CL], i_dn[c], i_dn[CR]};
        assign w_life = tla_pkg::life_rule(r_row[c], w_nb);
        assign w_hit  = i_ctl.wr && (CMP_W'(i_ctl.col) == CMP_W'(c));

        always_comb begin
            if (i_ctl.step) begin
                n_row[c] = w_life;
            end else if (w_hit) begin
                n_row[c] = i_ctl.val;
            end else begin
                n_row[c] = r_row[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

### rtl/toroidal_life_automaton.sv
// Top level of the toroidal life automaton: item handshake, row cells and result register.
//
//  channel  dir  handshake                  tdata
//  s        in   i_s_tvalid / o_s_tready    action, col, row, cell_in
//  m        out  o_m_tvalid / i_m_tready    cell_out, generation_count
//
// Writes, reads and a whole generation step are handled alike,
// since every row cell updates its own row in parallel from its neighbours.
// The result appears in the output register on the cycle after acceptance.
// A new item is taken while the held result is being taken in the same cycle.
// Reset clears the grid and the generation count at once; no sweep is needed.
`default_nettype none

module toroidal_life_automaton #(
    parameter int WIDTH  = 16,
    parameter int HEIGHT = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [1:0] action, [5:2] col, [9:6] row, [10] cell_in, [15:11] zero
    input  wire logic [tla_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [0] cell_out, [32:1] generation_count, [39:33] zero
    output logic      [tla_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    localparam int CMP_W = 9;

    logic [tla_pkg::ACTION_W-1:0] w_action;
    logic [tla_pkg::COL_W-1:0]    w_col;
    logic [tla_pkg::ROW_W-1:0]    w_row;
    logic                         w_cell_in;
    logic                         w_accept;
    logic                         w_on_grid;
    logic                         w_is_write;
    logic                         w_is_step;
    logic                         w_rd_bit;
    logic                         w_result;

    logic [WIDTH-1:0] w_rows [HEIGHT];
    logic [HEIGHT-1:0] w_rd_hits;

    logic                      r_out_valid;
    logic                      r_cell_out;
    logic [tla_pkg::GEN_W-1:0] r_gen;
    logic [tla_pkg::GEN_W-1:0] n_gen;

    assign w_action  = i_s_tdata[1:0];
    assign w_col     = i_s_tdata[5:2];
    assign w_row     = i_s_tdata[9:6];
    assign w_cell_in = i_s_tdata[10];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_on_grid  = (CMP_W'(w_col) < CMP_W'(WIDTH)) && (CMP_W'(w_row) < CMP_W'(HEIGHT));

    always_comb begin
        w_is_write = 1'b0;
        w_is_step  = 1'b0;
        case (w_action)
            tla_pkg::ACT_WRITE: w_is_write = 1'b1;
            tla_pkg::ACT_STEP:  w_is_step  = 1'b1;
            default: begin
                w_is_write = 1'b0;
                w_is_step  = 1'b0;
            end
        endcase
    end

    for (genvar r = 0; r < HEIGHT; r++) begin : g_row
        localparam int UP = (r + HEIGHT - 1) % HEIGHT;
        localparam int DN = (r + 1) % HEIGHT;
        tla_pkg::t_cell_ctl w_ctl;
        logic               w_row_hit;
        logic [WIDTH-1:0]   w_col_hits;

        assign w_row_hit = (CMP_W'(w_row) == CMP_W'(r));
        assign w_ctl.step = w_accept && w_is_step;
        assign w_ctl.wr   = w_accept && w_is_write && w_on_grid && w_row_hit;
        assign w_ctl.col  = w_col;
        assign w_ctl.val  = w_cell_in;

        tla_row_cell #(
            .WIDTH (WIDTH)
        ) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_up    (w_rows[UP]),
            .i_dn    (w_rows[DN]),
            .i_ctl   (w_ctl),
            .o_row   (w_rows[r])
        );

        for (genvar c = 0; c < WIDTH; c++) begin : g_rd
            assign w_col_hits[c] = w_rows[r][c] && (CMP_W'(w_col) == CMP_W'(c));
        end
        assign w_rd_hits[r] = w_row_hit && (|w_col_hits);
    end

    assign w_rd_bit = |w_rd_hits;

    // A write answers with the value just written; off-grid addresses read as dead.
    always_comb begin
        n_gen = r_gen;
        if (w_is_step) begin
            n_gen    = r_gen + tla_pkg::GEN_W'(1);
            w_result = 1'b0;
        end else if (!w_on_grid) begin
            w_result = 1'b0;
        end else if (w_is_write) begin
            w_result = w_cell_in;
        end else begin
            w_result = w_rd_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_gen       <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_gen       <= n_gen;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cell_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_gen, r_cell_out};

`ifndef ASSERT_OFF
    a_step_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_step) |=> (r_gen == $past(r_gen) + tla_pkg::GEN_W'(1)))
        else $error("generation count did not advance on a step item");

    a_no_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_step) |=> $stable(r_gen))
        else $error("generation count changed without a step item");

    a_step_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_step) |=> (r_cell_out == 1'b0))
        else $error("step item answered with a live cell");

    a_write_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_write && w_on_grid) |=> (r_cell_out == $past(w_cell_in)))
        else $error("write item did not answer with the written value");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted item produced no result");
`endif

endmodule

`default_nettype wire

### dv/toroidal_life_automaton_test.sv
// Testbench for the toroidal life automaton: directed and random items against a grid predictor.
`timescale 1ns / 1ps

module toroidal_life_automaton_test;

    localparam int GRID_W      = 16;
    localparam int GRID_H      = 16;
    localparam int ITEM_TOTAL  = 1300;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 20;
    localparam int CYCLE_LIMIT = 200000;

    // The one action code the package leaves unnamed; it behaves as a read.
    localparam logic [tla_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic                      alive;
        logic [tla_pkg::GEN_W-1:0] gen;
    } t_life_answer;

    class life_grid_tracker;
        bit                        grid [GRID_H][GRID_W];
        bit [tla_pkg::GEN_W-1:0]   generations;
        t_life_answer              pending_answers[$];
        int unsigned               faults;

        function void advance();
            bit          fresh [GRID_H][GRID_W];
            int unsigned n;
            int          ru, rd, cl, cr;
            for (int r = 0; r < GRID_H; r++) begin
                ru = (r + GRID_H - 1) % GRID_H;
                rd = (r + 1) % GRID_H;
                for (int c = 0; c < GRID_W; c++) begin
                    cl = (c + GRID_W - 1) % GRID_W;
                    cr = (c + 1) % GRID_W;
                    n = grid[ru][cl] + grid[ru][c] + grid[ru][cr]
                      + grid[r][cl] + grid[r][cr]
                      + grid[rd][cl] + grid[rd][c] + grid[rd][cr];
                    fresh[r][c] = (n == tla_pkg::BIRTH_COUNT)
                               || ((n == tla_pkg::SURVIVE_COUNT) && grid[r][c]);
                end
            end
            grid = fresh;
            generations = generations + 1;
        endfunction

        // Works out the answer to an accepted item and queues it.
        function void note_item(input logic [tla_pkg::S_TDATA_W-1:0] data);
            logic [tla_pkg::ACTION_W-1:0] act;
            int                           col, row;
            bit                           on_grid;
            t_life_answer                 ans;
            act     = data[1:0];
            col     = int'(data[5:2]);
            row     = int'(data[9:6]);
            on_grid = (col < GRID_W) && (row < GRID_H);
            ans.alive = 1'b0;
            if (act == tla_pkg::ACT_STEP) begin
                advance();
            end else begin
                if (act == tla_pkg::ACT_WRITE && on_grid) begin
                    grid[row][col] = data[10];
                end
                if (on_grid) begin
                    ans.alive = grid[row][col];
                end
            end
            ans.gen = generations;
            pending_answers.push_back(ans);
        endfunction

        function void check_result(input logic [tla_pkg::M_TDATA_W-1:0] data);
            t_life_answer want;
            if (pending_answers.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("unexpected result: cell %0b gen %0d", data[0], data[32:1]);
                end
            end else begin
                want = pending_answers.pop_front();
                if (data[0] !== want.alive || data[32:1] !== want.gen) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("result mismatch: expected cell %0b gen %0d, got cell %0b gen %0d",
                                 want.alive, want.gen, data[0], data[32:1]);
                    end
                end
            end
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    // [1:0] action, [5:2] col, [9:6] row, [10] cell_in, [15:11] zero
    logic [tla_pkg::S_TDATA_W-1:0] i_s_tdata;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    // [0] cell_out, [32:1] generation_count, [39:33] zero
    logic [tla_pkg::M_TDATA_W-1:0] o_m_tdata;

    life_grid_tracker tracker;
    int unsigned      items_sent;
    int unsigned      cycles;
    bit               calm;
    bit               hold_req;

    toroidal_life_automaton #(
        .WIDTH  (GRID_W),
        .HEIGHT (GRID_H)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The input is noted before the output is checked, so the order holds for any latency.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                tracker.note_item(i_s_tdata);
            end
            if (o_m_tvalid && i_m_tready) begin
                tracker.check_result(o_m_tdata);
            end
        end
    end

    // Receiver: short random stalls, one long hold-off, none once the run calms down.
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    task automatic send_item(input logic [tla_pkg::S_TDATA_W-1:0] data);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        calm = (items_sent >= ITEM_TOTAL - CALM_ITEMS);
        if (items_sent == HOLD_AT) begin
            hold_req = 1'b1;
        end
    endtask

    task automatic send_cell(input logic [tla_pkg::ACTION_W-1:0] act,
                             input logic [tla_pkg::COL_W-1:0] col,
                             input logic [tla_pkg::ROW_W-1:0] row, input logic val);
        send_item({5'd0, val, row, col, act});
    endtask

    initial begin
        int unsigned ox, oy;
        tracker    = new();
        items_sent = 0;
        cycles     = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Cleared grid, far corner, the spare code and killing a live cell.
        send_cell(tla_pkg::ACT_READ, 4'd0, 4'd0, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd15, 4'd15, 1'b1);
        send_cell(tla_pkg::ACT_READ, 4'd15, 4'd15, 1'b0);
        send_cell(ACT_SPARE, 4'd15, 4'd15, 1'b1);
        send_cell(ACT_SPARE, 4'd3, 4'd9, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd0, 4'd0, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd0, 4'd0, 1'b0);
        send_cell(tla_pkg::ACT_WRITE, 4'd7, 4'd7, 1'b0);
        // A blinker lying across the column wrap on row zero.
        send_cell(tla_pkg::ACT_WRITE, 4'd15, 4'd0, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd0, 4'd0, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd1, 4'd0, 1'b1);
        send_cell(tla_pkg::ACT_STEP, 4'd15, 4'd15, 1'b1);
        send_cell(tla_pkg::ACT_READ, 4'd0, 4'd15, 1'b0);
        send_cell(tla_pkg::ACT_READ, 4'd0, 4'd1, 1'b0);
        send_cell(tla_pkg::ACT_READ, 4'd15, 4'd0, 1'b0);
        send_cell(tla_pkg::ACT_STEP, 4'd0, 4'd0, 1'b0);
        send_cell(tla_pkg::ACT_READ, 4'd15, 4'd0, 1'b0);
        send_cell(tla_pkg::ACT_READ, 4'd1, 4'd0, 1'b0);
        // A glider near the corner, so it crosses both wraps.
        send_cell(tla_pkg::ACT_WRITE, 4'd14, 4'd13, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd15, 4'd14, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd13, 4'd15, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd14, 4'd15, 1'b1);
        send_cell(tla_pkg::ACT_WRITE, 4'd15, 4'd15, 1'b1);
        repeat (4) send_cell(tla_pkg::ACT_STEP, 4'd10, 4'd5, 1'b1);

        while (items_sent < ITEM_TOTAL) begin
            if ($urandom_range(0, 9) < 8) begin
                // Seed a small patch, let it evolve, then look around the patch.
                ox = $urandom_range(0, 15);
                oy = $urandom_range(0, 15);
                repeat ($urandom_range(3, 14)) begin
                    send_cell(tla_pkg::ACT_WRITE, 4'(ox + $urandom_range(0, 4)),
                              4'(oy + $urandom_range(0, 4)), $urandom_range(0, 9) < 7);
                end
                repeat ($urandom_range(1, 4)) begin
                    send_cell(tla_pkg::ACT_STEP, 4'($urandom), 4'($urandom), 1'($urandom));
                end
                repeat ($urandom_range(2, 6)) begin
                    send_cell(($urandom_range(0, 7) == 0) ? ACT_SPARE : tla_pkg::ACT_READ,
                              4'(ox + $urandom_range(0, 6) - 1),
                              4'(oy + $urandom_range(0, 6) - 1), 1'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_cell(2'($urandom), 4'($urandom), 4'($urandom), 1'($urandom));
                end
            end
        end

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (tracker.faults == 0 && tracker.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### toroidal_life_automaton.f
rtl/tla_pkg.sv
rtl/tla_row_cell.sv
rtl/toroidal_life_automaton.sv
dv/toroidal_life_automaton_test.sv
